>>> design/cxlc_pkg.sv
// Package for the committed transaction id cache.
// Holds sizes, the stored entry layout and the sequencer state type.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package cxlc_pkg;

  // Number of entries the cache can hold.
  localparam int unsigned NumEntries = 64;
  // Width of an entry index and of an age rank.
  localparam int unsigned IdxW = $clog2(NumEntries);
  // Width of an entry count; it can hold NumEntries itself.
  localparam int unsigned CntW = IdxW + 1;
  // Width of the capacity register.
  localparam int unsigned CapW = 7;
  // Width of the key and value fields.
  localparam int unsigned XidW = 32;

  // One stored entry: key, value and recency rank (zero is most recent).
  typedef struct packed {
    logic [XidW-1:0] key;
    logic [XidW-1:0] value;
    logic [IdxW-1:0] age;
  } entry_t;

  localparam int unsigned EntryW = $bits(entry_t);

  // Operation codes carried in tuser.
  localparam logic FuncLookup = 1'b0;
  localparam logic FuncAdd    = 1'b1;

  // Sequencer states.
  typedef enum logic [1:0] {
    StIdle,
    StScan,
    StUpdate,
    StResp
  } state_e;

endpackage
`default_nettype wire

>>> design/cxlc_ram.sv
// Simple dual-port synchronous RAM holding the cache entries.
// Read data is registered. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module cxlc_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule
`default_nettype wire

>>> design/committed_xid_lru_cache.sv
// Committed transaction id cache, top level: fully associative LRU store.
// Depends on cxlc_pkg and cxlc_ram.
//
// Usage:
//   The input stream carries one item per operation: tuser[0] selects a
//   lookup (0) or an add (1); tdata holds the local id (key, low 32 bits)
//   and the distributed id to store (high 32 bits). The output stream
//   returns exactly one item per input item: tdata holds the stored
//   distributed id on a lookup hit (else zero), tuser[0] is the hit flag
//   and tuser[1] the duplicate flag of an add.
//   The capacity register sits at APB address 0 (7 bits, reset 64).
// Timing:
//   Entries live in a dual-port RAM swept one entry per cycle. Every
//   item with a nonzero capacity takes one sweep that matches keys (and
//   on an add evicts and picks a free slot); a lookup hit or a real add
//   takes a second sweep that rewrites the age ranks. The result is then
//   loaded in the response state; a zero capacity skips both sweeps.
// Reset and stalls:
//   Reset empties the cache through per-entry valid flops, so no clearing
//   pass is needed. The result waits in an output register; the next item
//   is accepted while it waits, and a new result only stalls the sequencer
//   if the previous one has not been taken yet.
`timescale 1ns / 1ps
`default_nettype none
module committed_xid_lru_cache (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // Input items.
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  // tdata: [31:0] local_xid, [63:32] distrib_xid_in
  input  wire logic [63:0] s_axis_tdata_i,
  // tuser: [0] func
  input  wire logic [0:0]  s_axis_tuser_i,
  // Result items.
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  // tdata: [31:0] distrib_xid_out
  output logic      [31:0] m_axis_tdata_o,
  // tuser: [0] hit, [1] duplicate
  output logic      [1:0]  m_axis_tuser_o,
  // Configuration port.
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready
);

  localparam int unsigned N    = cxlc_pkg::NumEntries;
  localparam int unsigned IdxW = cxlc_pkg::IdxW;
  localparam int unsigned CntW = cxlc_pkg::CntW;
  localparam int unsigned CapW = cxlc_pkg::CapW;
  localparam int unsigned XidW = cxlc_pkg::XidW;
  localparam int unsigned CmpW = (CntW > CapW) ? CntW : CapW;

  // Configuration register.
  logic [CapW-1:0] capacity_q;

  assign pready = 1'b1;
  assign prdata = {{(32 - CapW){1'b0}}, capacity_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      capacity_q <= CapW'(N > 127 ? 127 : N);
    end else if (psel && penable && pwrite && pready && (paddr == 3'd0)) begin
      capacity_q <= pwdata[CapW-1:0];
    end
  end

  // Effective capacity, clipped to the number of entries.
  logic [CntW-1:0] cap_w;
  always_comb begin
    if (CmpW'(capacity_q) > CmpW'(N)) begin
      cap_w = CntW'(N);
    end else begin
      cap_w = CntW'(capacity_q);
    end
  end

  // Sequencer and item registers.
  cxlc_pkg::state_e state_q, state_d;
  logic [CntW-1:0] cnt_q;
  logic            func_q;
  logic [XidW-1:0] key_q, val_q;
  logic [N-1:0]    valid_q;
  logic [CntW-1:0] count_q;

  // Scan results.
  logic            found_q;
  logic [IdxW-1:0] slot_q;
  logic [IdxW-1:0] hit_age_q;
  logic [XidW-1:0] hit_val_q;
  logic            free_found_q;
  logic [IdxW-1:0] free_q;

  // Output register.
  logic            out_vld_q;
  logic [XidW-1:0] out_data_q;
  logic            out_hit_q, out_dup_q;

  // RAM interface.
  logic                   ram_we;
  logic [IdxW-1:0]        ram_raddr;
  cxlc_pkg::entry_t       ram_wdata;
  logic [cxlc_pkg::EntryW-1:0] ram_rdata_raw;
  cxlc_pkg::entry_t       ram_rdata;

  // Sweep position: address being read, and entry whose data arrives.
  logic [IdxW-1:0] jdx;
  logic            sweep_end, data_vld;

  cxlc_ram #(
    .Width(cxlc_pkg::EntryW),
    .Depth(N)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(jdx),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata_raw)
  );

  assign ram_rdata = cxlc_pkg::entry_t'(ram_rdata_raw);

  assign jdx       = IdxW'(cnt_q - CntW'(1));
  assign ram_raddr = cnt_q[IdxW-1:0];
  assign sweep_end = (cnt_q == CntW'(N));
  assign data_vld  = (cnt_q != '0);

  logic in_acc, out_free, disabled;
  assign in_acc   = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free = !out_vld_q || m_axis_tready_i;
  assign disabled = (cap_w == '0);

  // Per-entry decisions during the scan sweep.
  logic evict_on, ev, live, match;
  assign evict_on = (func_q == cxlc_pkg::FuncAdd) && (count_q >= cap_w);
  assign ev       = valid_q[jdx] && evict_on &&
                    ({1'b0, ram_rdata.age} >= (cap_w - CntW'(1)));
  assign live     = valid_q[jdx] && !ev;
  assign match    = live && (ram_rdata.key == key_q);

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      cxlc_pkg::StIdle: begin
        if (in_acc) begin
          state_d = disabled ? cxlc_pkg::StResp : cxlc_pkg::StScan;
        end
      end
      cxlc_pkg::StScan: begin
        if (sweep_end) begin
          if (found_q || match) begin
            state_d = (func_q == cxlc_pkg::FuncAdd) ? cxlc_pkg::StResp
                                                    : cxlc_pkg::StUpdate;
          end else begin
            state_d = (func_q == cxlc_pkg::FuncAdd) ? cxlc_pkg::StUpdate
                                                    : cxlc_pkg::StResp;
          end
        end
      end
      cxlc_pkg::StUpdate: begin
        if (sweep_end) begin
          state_d = cxlc_pkg::StResp;
        end
      end
      cxlc_pkg::StResp: begin
        if (out_free) begin
          state_d = cxlc_pkg::StIdle;
        end
      end
      default: state_d = cxlc_pkg::StIdle;
    endcase
  end

  // Outputs of the sequencer: ready and the write-back of the age sweep.
  always_comb begin
    s_axis_tready_o = (state_q == cxlc_pkg::StIdle);
    ram_we          = 1'b0;
    ram_wdata       = ram_rdata;
    if (state_q == cxlc_pkg::StUpdate && data_vld) begin
      ram_we = 1'b1;
      if (func_q == cxlc_pkg::FuncAdd) begin
        if (jdx == free_q) begin
          ram_wdata.key   = key_q;
          ram_wdata.value = val_q;
          ram_wdata.age   = '0;
        end else if (valid_q[jdx]) begin
          ram_wdata.age = ram_rdata.age + IdxW'(1);
        end
      end else begin
        if (jdx == slot_q) begin
          ram_wdata.age = '0;
        end else if (valid_q[jdx] && (ram_rdata.age < hit_age_q)) begin
          ram_wdata.age = ram_rdata.age + IdxW'(1);
        end
      end
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= cxlc_pkg::StIdle;
      cnt_q        <= '0;
      valid_q      <= '0;
      count_q      <= '0;
      found_q      <= 1'b0;
      free_found_q <= 1'b0;
      out_vld_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      // A new result replaces the taken one; otherwise a taken result clears.
      if (state_q == cxlc_pkg::StResp && out_free) begin
        out_vld_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_vld_q <= 1'b0;
      end
      case (state_q)
        cxlc_pkg::StIdle: begin
          cnt_q        <= '0;
          found_q      <= 1'b0;
          free_found_q <= 1'b0;
        end
        cxlc_pkg::StScan: begin
          cnt_q <= sweep_end ? '0 : cnt_q + CntW'(1);
          if (data_vld) begin
            if (ev) begin
              valid_q[jdx] <= 1'b0;
            end
            if (match) begin
              found_q <= 1'b1;
            end
            if (!live) begin
              free_found_q <= 1'b1;
            end
          end
          if (sweep_end && evict_on) begin
            count_q <= cap_w - CntW'(1);
          end
        end
        cxlc_pkg::StUpdate: begin
          cnt_q <= sweep_end ? '0 : cnt_q + CntW'(1);
          if (sweep_end && func_q == cxlc_pkg::FuncAdd) begin
            valid_q[free_q] <= 1'b1;
            count_q         <= count_q + CntW'(1);
          end
        end
        cxlc_pkg::StResp: begin
        end
        default: begin
          cnt_q <= '0;
        end
      endcase
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      func_q <= s_axis_tuser_i[0];
      key_q  <= s_axis_tdata_i[XidW-1:0];
      val_q  <= s_axis_tdata_i[2*XidW-1:XidW];
    end
    if (state_q == cxlc_pkg::StScan && data_vld) begin
      if (match && !found_q) begin
        slot_q    <= jdx;
        hit_age_q <= ram_rdata.age;
        hit_val_q <= ram_rdata.value;
      end
      if (!live && !free_found_q) begin
        free_q <= jdx;
      end
    end
    if (state_q == cxlc_pkg::StResp && out_free) begin
      if (disabled) begin
        out_hit_q  <= 1'b0;
        out_dup_q  <= 1'b0;
        out_data_q <= '0;
      end else begin
        out_hit_q  <= found_q && (func_q == cxlc_pkg::FuncLookup);
        out_dup_q  <= found_q && (func_q == cxlc_pkg::FuncAdd);
        out_data_q <= (found_q && func_q == cxlc_pkg::FuncLookup) ? hit_val_q : '0;
      end
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tuser_o  = {out_dup_q, out_hit_q};

  // The held count always agrees with the valid flags between items.
  a_count_matches : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == cxlc_pkg::StIdle) |-> ($countones(valid_q) == count_q))
    else $error("entry count disagrees with valid flags");

  // The RAM is only written during the age sweep.
  a_write_in_update : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (state_q == cxlc_pkg::StUpdate))
    else $error("RAM write outside the update sweep");

  // An add that reaches the update sweep has a free slot.
  a_free_slot : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == cxlc_pkg::StUpdate && func_q == cxlc_pkg::FuncAdd) |-> free_found_q)
    else $error("add without a free slot");

  // The held count never exceeds the number of entries.
  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(N))
    else $error("entry count out of range");

endmodule
`default_nettype wire
